// File: hw/rtl/rvcad_pkg.sv
// Package for the control and ALU-operation decoder: opcode constants,
// ALU operation codes, the control flag bundle and the decode functions.
// No dependencies.
package rvcad_pkg;

    // Major opcodes (instruction bits 6..0)
    localparam logic [6:0] OP_RTYPE  = 7'b0110011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_ITYPE  = 7'b0010011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_MULX   = 7'b0000001;  // nonstandard multiply opcode, kept
    localparam logic [6:0] OP_FLOAD  = 7'b0000111;
    localparam logic [6:0] OP_FSTORE = 7'b0100111;
    localparam logic [6:0] OP_FARITH = 7'b1010011;
    localparam logic [6:0] OP_FENCE  = 7'b0000000;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_IMMW   = 7'b0011011;

    // funct7 values of interest
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_MEXT = 7'b0000001;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values of interest
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    typedef enum logic [4:0] {
        ALU_ADD    = 5'd0,
        ALU_SUB    = 5'd1,
        ALU_MUL    = 5'd2,
        ALU_SLL    = 5'd3,
        ALU_MULH   = 5'd4,
        ALU_SLT    = 5'd5,
        ALU_MULHSU = 5'd6,
        ALU_SLTU   = 5'd7,
        ALU_MULHU  = 5'd8,
        ALU_XOR    = 5'd9,
        ALU_DIV    = 5'd10,
        ALU_SRL    = 5'd11,
        ALU_SRA    = 5'd12,
        ALU_DIVU   = 5'd13,
        ALU_OR     = 5'd14,
        ALU_REM    = 5'd15,
        ALU_AND    = 5'd16,
        ALU_REMU   = 5'd17,
        ALU_NONE   = 5'd18,
        ALU_ADDW   = 5'd19,
        ALU_SLLW   = 5'd20,
        ALU_SRLW   = 5'd21,
        ALU_SRAW   = 5'd22
    } alu_op_t;

    typedef struct packed {
        logic alu_src;
        logic mem_to_reg;
        logic reg_write;
        logic mem_read;
        logic mem_write;
        logic branch;
        logic alu_used;
    } ctrl_t;

    // Base integer ops by funct3 (shared by R-type and I-type)
    function automatic alu_op_t base_op(input logic [2:0] f3);
        alu_op_t r;
        case (f3)
            F3_0:    r = ALU_ADD;
            F3_1:    r = ALU_SLL;
            F3_2:    r = ALU_SLT;
            F3_3:    r = ALU_SLTU;
            F3_4:    r = ALU_XOR;
            F3_5:    r = ALU_SRL;
            F3_6:    r = ALU_OR;
            default: r = ALU_AND;
        endcase
        return r;
    endfunction

    // Multiply/divide ops by funct3
    function automatic alu_op_t mext_op(input logic [2:0] f3);
        alu_op_t r;
        case (f3)
            F3_0:    r = ALU_MUL;
            F3_1:    r = ALU_MULH;
            F3_2:    r = ALU_MULHSU;
            F3_3:    r = ALU_MULHU;
            F3_4:    r = ALU_DIV;
            F3_5:    r = ALU_DIVU;
            F3_6:    r = ALU_REM;
            default: r = ALU_REMU;
        endcase
        return r;
    endfunction

    // ALU operation from opcode, funct3 and funct7; anything unmatched is add
    function automatic alu_op_t alu_decode(input logic [6:0] op,
                                           input logic [2:0] f3,
                                           input logic [6:0] f7);
        alu_op_t r;
        r = ALU_ADD;
        case (op)
            OP_RTYPE:
            begin
                if (f7 == F7_BASE)
                    r = base_op(f3);
                else if (f7 == F7_MEXT)
                    r = mext_op(f3);
                else if (f7 == F7_ALT && f3 == F3_0)
                    r = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_5)
                    r = ALU_SRA;
            end
            OP_ITYPE:
            begin
                if (f3 == F3_5)
                begin
                    if (f7 == F7_BASE)
                        r = ALU_SRL;
                    else if (f7 == F7_ALT)
                        r = ALU_SRA;
                end
                else
                    r = base_op(f3);
            end
            OP_BRANCH:
            begin
                if (f3 inside {F3_0, F3_1})
                    r = ALU_SUB;
                else if (f3 inside {F3_4, F3_5})
                    r = ALU_SLT;
                else if (f3 inside {F3_6, F3_7})
                    r = ALU_SLTU;
            end
            OP_FENCE:
                r = ALU_NONE;
            OP_SYSTEM:
            begin
                if (f3 inside {F3_0, F3_1})
                    r = ALU_NONE;
            end
            OP_IMMW:
            begin
                if (f3 == F3_0)
                    r = ALU_ADDW;
                else if (f3 == F3_1)
                    r = ALU_SLLW;
                else if (f3 == F3_5 && f7 == F7_BASE)
                    r = ALU_SRLW;
                else if (f3 == F3_5 && f7 == F7_ALT)
                    r = ALU_SRAW;
            end
            default:
                r = ALU_ADD;
        endcase
        return r;
    endfunction

    // Pipeline control flags from the opcode; unknown opcodes clear all
    function automatic ctrl_t ctrl_decode(input logic [6:0] op);
        ctrl_t c;
        c = '0;
        case (op)
            OP_RTYPE, OP_MULX, OP_FARITH:
            begin
                c.reg_write = 1'b1;
                c.alu_used  = 1'b1;
            end
            OP_LOAD, OP_FLOAD:
            begin
                c.alu_src    = 1'b1;
                c.mem_to_reg = 1'b1;
                c.reg_write  = 1'b1;
                c.mem_read   = 1'b1;
            end
            OP_STORE, OP_FSTORE:
            begin
                c.alu_src   = 1'b1;
                c.alu_used  = 1'b1;
                c.mem_write = 1'b1;
            end
            OP_BRANCH:
            begin
                c.alu_used = 1'b1;
                c.branch   = 1'b1;
            end
            OP_ITYPE, OP_LUI, OP_AUIPC:
            begin
                c.alu_src   = 1'b1;
                c.reg_write = 1'b1;
                c.alu_used  = 1'b1;
            end
            OP_JAL:
            begin
                c.reg_write = 1'b1;
                c.branch    = 1'b1;
            end
            OP_JALR:
            begin
                c.alu_src   = 1'b1;
                c.reg_write = 1'b1;
                c.branch    = 1'b1;
            end
            default:
                c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/riscv_control_and_alu_decode_core.sv
// Control and ALU-operation decoder, top level.
// Depends on rvcad_pkg for opcodes, ALU codes and the decode functions.
//
// Usage:
//   Request channel: instruction with req_valid / req_ready. One 32-bit
//   instruction word per request.
//   Result channel: seven control flags and a 5-bit alu_operation with
//   res_valid / res_ready. Exactly one result per request, in order.
//   Latency: the result is presented the cycle after the request is taken.
//   Throughput: one request per cycle while res_ready is high; the decode is a
//   single pass of table logic from the request port into the result register.
//   Stall: while a result waits and res_ready is low, req_ready is low and
//   the result register holds. A request is still taken in the same cycle
//   that the waiting result leaves, so a ready receiver sees no bubbles.
//   Reset: rst_n clears the result valid flag; the payload registers are not reset.
module riscv_control_and_alu_decode_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [31:0] instruction,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        alu_src,
    output logic        mem_to_reg,
    output logic        reg_write,
    output logic        mem_read,
    output logic        mem_write,
    output logic        branch,
    output logic        alu_used,
    output logic [4:0]  alu_operation
);
    import rvcad_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    ctrl_t   ctrl_reg;
    ctrl_t   ctrl_next;
    alu_op_t alu_op_reg;
    alu_op_t alu_op_next;
    logic    take;

    // Field split and decode
    always_comb
    begin
        ctrl_next   = ctrl_decode(instruction[6:0]);
        alu_op_next = alu_decode(instruction[6:0], instruction[14:12],
                                 instruction[31:25]);
    end

    // Result register accepts a new request when empty or being drained
    assign req_ready  = !valid_reg || res_ready;
    assign take       = req_valid && req_ready;
    assign valid_next = take || (valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctrl_reg   <= ctrl_next;
            alu_op_reg <= alu_op_next;
        end
    end

    // Outputs
    assign res_valid     = valid_reg;
    assign alu_src       = ctrl_reg.alu_src;
    assign mem_to_reg    = ctrl_reg.mem_to_reg;
    assign reg_write     = ctrl_reg.reg_write;
    assign mem_read      = ctrl_reg.mem_read;
    assign mem_write     = ctrl_reg.mem_write;
    assign branch        = ctrl_reg.branch;
    assign alu_used      = ctrl_reg.alu_used;
    assign alu_operation = alu_op_reg;

endmodule
